>>> rtl/core/txs_pkg.sv
// shared types and constants for the tx request frame serializer
`timescale 1ns / 1ps
`default_nettype none

package txs_pkg;

  // frame format constants
  localparam logic [7:0]  Delimiter  = 8'h7E;
  localparam logic [7:0]  FrameType  = 8'h10;
  localparam logic [15:0] LenBase    = 16'd14;
  localparam int unsigned MaxPayload = 255;

  // position of a byte within the frame header
  typedef logic [4:0] hdr_idx_t;

  localparam hdr_idx_t HdrDelim   = 5'd0;
  localparam hdr_idx_t HdrLenHi   = 5'd1;
  localparam hdr_idx_t HdrLenLo   = 5'd2;
  localparam hdr_idx_t HdrType    = 5'd3;
  localparam hdr_idx_t HdrId      = 5'd4;
  localparam hdr_idx_t HdrDest0   = 5'd5;
  localparam hdr_idx_t HdrDest1   = 5'd6;
  localparam hdr_idx_t HdrDest2   = 5'd7;
  localparam hdr_idx_t HdrDest3   = 5'd8;
  localparam hdr_idx_t HdrDest4   = 5'd9;
  localparam hdr_idx_t HdrDest5   = 5'd10;
  localparam hdr_idx_t HdrDest6   = 5'd11;
  localparam hdr_idx_t HdrDest7   = 5'd12;
  localparam hdr_idx_t HdrNetHi   = 5'd13;
  localparam hdr_idx_t HdrNetLo   = 5'd14;
  localparam hdr_idx_t HdrRadius  = 5'd15;
  localparam hdr_idx_t HdrOptions = 5'd16;

  // one output byte on its way to the output register
  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       item_end;
  } out_beat_t;

  // sequencer status seen by the top level checks
  typedef struct packed {
    logic     cur_valid;
    logic     in_frame;
    hdr_idx_t hdr_idx;
  } txs_status_t;

endpackage

`default_nettype wire

>>> rtl/core/txs_if.sv
// request and byte stream channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface txs_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_id;
  logic [63:0] dest_addr;
  logic [15:0] net_addr;
  logic [7:0]  radius;
  logic [7:0]  options;
  logic [7:0]  payload_len;
  logic [7:0]  data_byte;

  modport source (
    output valid, frame_id, dest_addr, net_addr, radius, options, payload_len, data_byte,
    input  ready
  );
  modport sink (
    input  valid, frame_id, dest_addr, net_addr, radius, options, payload_len, data_byte,
    output ready
  );
endinterface

interface txs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       item_end;

  modport source (
    output valid, out_byte, frame_end, item_end,
    input  ready
  );
  modport sink (
    input  valid, out_byte, frame_end, item_end,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/txs_sequencer.sv
// request register, frame state and byte selection
`timescale 1ns / 1ps
`default_nettype none

module txs_sequencer (
  input  logic                clk,
  input  logic                rst,
  txs_req_if.sink             req,
  output txs_pkg::out_beat_t  beat,
  output logic                beat_valid,
  input  logic                beat_ready,
  output txs_pkg::txs_status_t status
);
  import txs_pkg::*;

  // held request
  logic        cur_valid;
  logic [7:0]  cur_frame_id;
  logic [63:0] cur_dest_addr;
  logic [15:0] cur_net_addr;
  logic [7:0]  cur_radius;
  logic [7:0]  cur_options;
  logic [7:0]  cur_payload_len;
  logic [7:0]  cur_data_byte;

  // frame state
  hdr_idx_t    hdr_idx;
  logic        data_done;
  logic        in_frame;
  logic [7:0]  bytes_left;
  logic [7:0]  running_sum;

  logic        emit;
  logic        item_last;
  logic        take;
  logic [7:0]  n_clamp;
  logic [15:0] flen;
  logic [7:0]  hdr_byte;
  logic        send_hdr;
  logic        send_data;
  logic        sum_add;

  // length field from clamped payload count
  always_comb begin
    if ({8'h00, cur_payload_len} > 16'(MaxPayload)) begin
      n_clamp = 8'(MaxPayload);
    end else begin
      n_clamp = cur_payload_len;
    end
    flen = LenBase + {8'h00, n_clamp};
  end

  // header byte select
  always_comb begin
    unique case (hdr_idx)
      HdrDelim:   hdr_byte = Delimiter;
      HdrLenHi:   hdr_byte = flen[15:8];
      HdrLenLo:   hdr_byte = flen[7:0];
      HdrType:    hdr_byte = FrameType;
      HdrId:      hdr_byte = cur_frame_id;
      HdrDest0:   hdr_byte = cur_dest_addr[63:56];
      HdrDest1:   hdr_byte = cur_dest_addr[55:48];
      HdrDest2:   hdr_byte = cur_dest_addr[47:40];
      HdrDest3:   hdr_byte = cur_dest_addr[39:32];
      HdrDest4:   hdr_byte = cur_dest_addr[31:24];
      HdrDest5:   hdr_byte = cur_dest_addr[23:16];
      HdrDest6:   hdr_byte = cur_dest_addr[15:8];
      HdrDest7:   hdr_byte = cur_dest_addr[7:0];
      HdrNetHi:   hdr_byte = cur_net_addr[15:8];
      HdrNetLo:   hdr_byte = cur_net_addr[7:0];
      HdrRadius:  hdr_byte = cur_radius;
      HdrOptions: hdr_byte = cur_options;
      default:    hdr_byte = 8'h00;
    endcase
  end

  // pick header, payload or checksum byte
  always_comb begin
    send_hdr  = !in_frame;
    send_data = in_frame && !data_done && (bytes_left != 8'h00);
    beat      = '0;
    item_last = 1'b0;
    sum_add   = 1'b0;
    if (send_hdr) begin
      beat.out_byte = hdr_byte;
      sum_add       = (hdr_idx >= HdrType);
    end else if (send_data) begin
      beat.out_byte = cur_data_byte;
      item_last     = (bytes_left != 8'h01);
      beat.item_end = item_last;
      sum_add       = 1'b1;
    end else begin
      beat.out_byte  = ~running_sum;
      beat.frame_end = 1'b1;
      beat.item_end  = 1'b1;
      item_last      = 1'b1;
    end
  end

  assign beat_valid = cur_valid;
  assign emit       = cur_valid && beat_ready;
  assign req.ready  = !cur_valid || (emit && item_last);
  assign take       = req.valid && req.ready;

  // request register
  always_ff @(posedge clk) begin
    if (take) begin
      cur_frame_id    <= req.frame_id;
      cur_dest_addr   <= req.dest_addr;
      cur_net_addr    <= req.net_addr;
      cur_radius      <= req.radius;
      cur_options     <= req.options;
      cur_payload_len <= req.payload_len;
      cur_data_byte   <= req.data_byte;
    end
  end

  // control and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid   <= 1'b0;
      hdr_idx     <= HdrDelim;
      data_done   <= 1'b0;
      in_frame    <= 1'b0;
      bytes_left  <= 8'h00;
      running_sum <= 8'h00;
    end else begin
      if (emit) begin
        if (sum_add) begin
          running_sum <= running_sum + beat.out_byte;
        end
        if (send_hdr) begin
          if (hdr_idx == HdrOptions) begin
            hdr_idx    <= HdrDelim;
            in_frame   <= 1'b1;
            bytes_left <= n_clamp;
          end else begin
            hdr_idx <= hdr_idx + 5'd1;
          end
        end else if (send_data) begin
          bytes_left <= bytes_left - 8'h01;
        end else begin
          in_frame    <= 1'b0;
          running_sum <= 8'h00;
        end
      end
      // a new request clears the payload mark, otherwise a sent payload byte sets it
      if (take) begin
        cur_valid <= 1'b1;
        data_done <= 1'b0;
      end else begin
        if (emit && item_last) begin
          cur_valid <= 1'b0;
        end
        if (emit && send_data) begin
          data_done <= 1'b1;
        end
      end
    end
  end

  assign status.cur_valid = cur_valid;
  assign status.in_frame  = in_frame;
  assign status.hdr_idx   = hdr_idx;

endmodule

`default_nettype wire

>>> rtl/core/txs_out_reg.sv
// output byte register between the sequencer and the byte stream
`timescale 1ns / 1ps
`default_nettype none

module txs_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  txs_pkg::out_beat_t beat,
  input  logic               beat_valid,
  output logic               beat_ready,
  txs_byte_if.source         frame
);
  import txs_pkg::*;

  logic      valid;
  out_beat_t held;

  // load whenever empty or being drained
  assign beat_ready = !valid || frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (beat_ready) begin
      valid <= beat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_ready && beat_valid) begin
      held <= beat;
    end
  end

  assign frame.valid     = valid;
  assign frame.out_byte  = held.out_byte;
  assign frame.frame_end = held.frame_end;
  assign frame.item_end  = held.item_end;

endmodule

`default_nettype wire

>>> rtl/core/tx_request_frame_serializer.sv
// top level of the tx request frame serializer
// a request's first byte is loaded into the output register before it is valid on
// the output
// throughput: one output byte per cycle while the byte stream is ready; a payload
// request gives one byte, the closing payload request two, and a frame's first request
// 18 bytes (17 header bytes plus payload byte or checksum), 19 when the payload is one byte
// reset: synchronous; clears the held request, output register and frame state
`timescale 1ns / 1ps
`default_nettype none

module tx_request_frame_serializer (
  input  logic       clk,
  input  logic       rst,
  txs_req_if.sink    req,
  txs_byte_if.source frame
);
  import txs_pkg::*;

  out_beat_t   beat;
  logic        beat_valid;
  logic        beat_ready;
  txs_status_t status;

  // byte selection and frame state
  txs_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .beat       (beat),
    .beat_valid (beat_valid),
    .beat_ready (beat_ready),
    .status     (status)
  );

  // output register
  txs_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .beat       (beat),
    .beat_valid (beat_valid),
    .beat_ready (beat_ready),
    .frame      (frame)
  );

`ifndef SYNTHESIS
  // header counter rests at the delimiter once the header is out
  a_hdr_idle: assert property (@(posedge clk) disable iff (rst)
    status.in_frame |-> status.hdr_idx == HdrDelim)
    else $error("header index not at rest during payload");

  // a checksum byte always closes its request
  a_frame_end_item: assert property (@(posedge clk) disable iff (rst)
    frame.valid && frame.frame_end |-> frame.item_end)
    else $error("frame end without item end");

  // after the checksum leaves, no frame is open yet
  a_frame_closed: assert property (@(posedge clk) disable iff (rst)
    frame.valid && frame.ready && frame.frame_end |=> !status.in_frame)
    else $error("frame open right after checksum");

  // a new request is only taken into a free or finishing register
  a_take_free: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && status.cur_valid |-> beat_ready)
    else $error("request taken while held request still busy");
`endif

endmodule

`default_nettype wire
